/* hw/rtl/hcpt_pkg.sv */
// ----------------------------------------------------------------------------
// hcpt_pkg
// Shared constants, register indexes and types of the Hermite curve point
// transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hcpt_pkg;

  localparam int T_FRAC_BITS_DEF    = 16;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  localparam int COORD_W    = 16;
  localparam int T_IN_W     = 17;
  localparam int TRIG_W     = 16;
  localparam int SCALE_W    = 16;
  localparam int CENTER_W   = 12;
  localparam int COLOR_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // blended point width, the same for any t fraction width
  localparam int BLEND_W = 22;

  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR = 3'd6;

  typedef struct packed {
    logic [COORD_W-1:0] tan_end_y;
    logic [COORD_W-1:0] tan_end_x;
    logic [COORD_W-1:0] tan_start_y;
    logic [COORD_W-1:0] tan_start_x;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] start_x;
  } seg_t;

  typedef struct packed {
    logic [TRIG_W-1:0]   cos_angle;
    logic [TRIG_W-1:0]   sin_angle;
    logic [SCALE_W-1:0]  scale_x;
    logic [SCALE_W-1:0]  scale_y;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [COLOR_W-1:0]  draw_color;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cos_angle:  16'h4000,
    sin_angle:  16'h0000,
    scale_x:    16'h1000,
    scale_y:    16'h1000,
    center_x:   12'h000,
    center_y:   12'h000,
    draw_color: 4'hf
  };

endpackage

`default_nettype wire

/* hw/rtl/hcpt_basis.sv */
// ----------------------------------------------------------------------------
// hcpt_basis
// Three pipeline stages: clamp t and square it, cube it, then form the four
// Hermite basis weights.
// ----------------------------------------------------------------------------
`default_nettype none

module hcpt_basis #(
  parameter int T_FRAC_BITS = hcpt_pkg::T_FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [hcpt_pkg::T_IN_W-1:0]        in_t,
  input  wire hcpt_pkg::seg_t                     in_seg,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [T_FRAC_BITS+3:0]           h00,
  output logic signed [T_FRAC_BITS+3:0]           h01,
  output logic signed [T_FRAC_BITS+3:0]           h10,
  output logic signed [T_FRAC_BITS+3:0]           h11,
  output hcpt_pkg::seg_t                          out_seg
);

  localparam int TW = (T_FRAC_BITS + 1 > hcpt_pkg::T_IN_W) ? hcpt_pkg::T_IN_W
                                                           : T_FRAC_BITS + 1;
  localparam int HW = T_FRAC_BITS + 4;
  localparam logic [31:0] ONE_W = 32'd1 << T_FRAC_BITS;
  localparam logic signed [HW-1:0] ONE_H = {3'b000, 1'b1, {T_FRAC_BITS{1'b0}}};

  logic            v1, v2, v3;
  logic            r1, r2, r3;
  logic [31:0]     t_wide;
  logic [TW-1:0]   t_cl;
  logic [2*TW-1:0] sq, sq_sh, cube, cube_sh;

  logic [TW-1:0]   t_s1, t2_s1;
  hcpt_pkg::seg_t  seg_s1;
  logic [TW-1:0]   t_s2, t2_s2, t3_s2;
  hcpt_pkg::seg_t  seg_s2;

  logic signed [HW-1:0] te, t2e, t3e;

  assign r3 = !v3 || out_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready  = r1;
  assign out_valid = v3;

  // t above one saturates to one
  assign t_wide  = {{(32-hcpt_pkg::T_IN_W){1'b0}}, in_t};
  assign t_cl    = (t_wide > ONE_W) ? ONE_W[TW-1:0] : t_wide[TW-1:0];
  assign sq      = t_cl * t_cl;
  assign sq_sh   = sq >> T_FRAC_BITS;
  assign cube    = t2_s1 * t_s1;
  assign cube_sh = cube >> T_FRAC_BITS;

  assign te  = $signed({{(HW-TW){1'b0}}, t_s2});
  assign t2e = $signed({{(HW-TW){1'b0}}, t2_s2});
  assign t3e = $signed({{(HW-TW){1'b0}}, t3_s2});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      t_s1   <= t_cl;
      t2_s1  <= sq_sh[TW-1:0];
      seg_s1 <= in_seg;
    end
    if (r2 && v1) begin
      t_s2   <= t_s1;
      t2_s2  <= t2_s1;
      t3_s2  <= cube_sh[TW-1:0];
      seg_s2 <= seg_s1;
    end
    if (r3 && v2) begin
      h00     <= (t3e <<< 1) - t2e - (t2e <<< 1) + ONE_H;
      h01     <= (t2e <<< 1) + t2e - (t3e <<< 1);
      h10     <= t3e - (t2e <<< 1) + te;
      h11     <= t3e - t2e;
      out_seg <= seg_s2;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hcpt_blend.sv */
// ----------------------------------------------------------------------------
// hcpt_blend
// Two pipeline stages: weight the end points and tangents, then sum and
// truncate toward zero into the blended curve point.
// ----------------------------------------------------------------------------
`default_nettype none

module hcpt_blend #(
  parameter int T_FRAC_BITS = hcpt_pkg::T_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [T_FRAC_BITS+3:0]        h00,
  input  wire logic signed [T_FRAC_BITS+3:0]        h01,
  input  wire logic signed [T_FRAC_BITS+3:0]        h10,
  input  wire logic signed [T_FRAC_BITS+3:0]        h11,
  input  wire hcpt_pkg::seg_t                       in_seg,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [hcpt_pkg::BLEND_W-1:0]       bx,
  output logic signed [hcpt_pkg::BLEND_W-1:0]       by
);

  localparam int HW = T_FRAC_BITS + 4;
  localparam int PW = HW + hcpt_pkg::COORD_W;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] RND = {{(SW-T_FRAC_BITS){1'b0}},
                                          {T_FRAC_BITS{1'b1}}};

  logic v4, v5, r4, r5;

  logic signed [PW-1:0] px0, px1, px2, px3, py0, py1, py2, py3;
  logic signed [SW-1:0] sum_x, sum_y, adj_x, adj_y, shx, shy;

  assign r5 = !v5 || out_ready;
  assign r4 = !v4 || r5;
  assign in_ready  = r4;
  assign out_valid = v5;

  assign sum_x = SW'(px0) + SW'(px1) + SW'(px2) + SW'(px3);
  assign sum_y = SW'(py0) + SW'(py1) + SW'(py2) + SW'(py3);
  // truncate toward zero
  assign adj_x = sum_x + (sum_x[SW-1] ? RND : '0);
  assign adj_y = sum_y + (sum_y[SW-1] ? RND : '0);
  assign shx   = adj_x >>> T_FRAC_BITS;
  assign shy   = adj_y >>> T_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r4) v4 <= in_valid;
      if (r5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && in_valid) begin
      px0 <= h00 * $signed(in_seg.start_x);
      px1 <= h01 * $signed(in_seg.end_x);
      px2 <= h10 * $signed(in_seg.tan_start_x);
      px3 <= h11 * $signed(in_seg.tan_end_x);
      py0 <= h00 * $signed(in_seg.start_y);
      py1 <= h01 * $signed(in_seg.end_y);
      py2 <= h10 * $signed(in_seg.tan_start_y);
      py3 <= h11 * $signed(in_seg.tan_end_y);
    end
    if (r5 && v4) begin
      bx <= shx[hcpt_pkg::BLEND_W-1:0];
      by <= shy[hcpt_pkg::BLEND_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hcpt_xform.sv */
// ----------------------------------------------------------------------------
// hcpt_xform
// Four pipeline stages: rotation products, rotation sums, axis scaling, then
// centre offset, truncation toward zero and saturation to screen range.
// ----------------------------------------------------------------------------
`default_nettype none

module hcpt_xform #(
  parameter int TRIG_FRAC_BITS = hcpt_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [hcpt_pkg::BLEND_W-1:0] bx,
  input  wire logic signed [hcpt_pkg::BLEND_W-1:0] by,
  input  wire hcpt_pkg::cfg_t                      cfg,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [hcpt_pkg::COORD_W-1:0]             pixel_x,
  output logic [hcpt_pkg::COORD_W-1:0]             pixel_y,
  output logic [hcpt_pkg::COLOR_W-1:0]             pixel_color
);

  localparam int MW  = hcpt_pkg::BLEND_W + hcpt_pkg::TRIG_W;
  localparam int RW  = MW + 1;
  localparam int SPW = RW + hcpt_pkg::SCALE_W + 1;
  localparam int VW  = SPW + 1;
  localparam int SH  = 16 + TRIG_FRAC_BITS;
  localparam logic signed [VW-1:0] RND   = {{(VW-SH){1'b0}}, {SH{1'b1}}};
  localparam logic signed [VW-1:0] MAX_V = VW'(32767);
  localparam logic signed [VW-1:0] MIN_V = -(VW'(32768));

  logic v6, v7, v8, v9;
  logic r6, r7, r8, r9;

  logic signed [MW-1:0]  pxc, pxs, pyc, pys;
  logic signed [RW-1:0]  rx, ry;
  logic signed [SPW-1:0] sx, sy;

  function automatic logic [hcpt_pkg::COORD_W-1:0] place(
    input logic signed [SPW-1:0]                prod,
    input logic [hcpt_pkg::CENTER_W-1:0]        center
  );
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] q;
    v = (VW'($signed(center)) <<< SH) + VW'(prod);
    v = v + (v[VW-1] ? RND : '0);
    q = v >>> SH;
    if (q > MAX_V) begin
      place = 16'h7fff;
    end else if (q < MIN_V) begin
      place = 16'h8000;
    end else begin
      place = q[hcpt_pkg::COORD_W-1:0];
    end
  endfunction

  assign r9 = !v9 || out_ready;
  assign r8 = !v8 || r9;
  assign r7 = !v7 || r8;
  assign r6 = !v6 || r7;
  assign in_ready  = r6;
  assign out_valid = v9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      if (r6) v6 <= in_valid;
      if (r7) v7 <= v6;
      if (r8) v8 <= v7;
      if (r9) v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (r6 && in_valid) begin
      pxc <= bx * $signed(cfg.cos_angle);
      pxs <= bx * $signed(cfg.sin_angle);
      pyc <= by * $signed(cfg.cos_angle);
      pys <= by * $signed(cfg.sin_angle);
    end
    if (r7 && v6) begin
      rx <= RW'(pxc) - RW'(pys);
      ry <= RW'(pxs) + RW'(pyc);
    end
    if (r8 && v7) begin
      sx <= rx * $signed({1'b0, cfg.scale_x});
      sy <= ry * $signed({1'b0, cfg.scale_y});
    end
    if (r9 && v8) begin
      pixel_x     <= place(sx, cfg.center_x);
      pixel_y     <= place(sy, cfg.center_y);
      pixel_color <= cfg.draw_color;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hermite_curve_point_transform.sv */
// throughput: one word per cycle while the output is not stalled, set by
// the nine-stage multiply pipeline
// a stalled output holds only the stages behind it that are full
// reset: synchronous, clears all stage valid bits and loads the register
// defaults (unit rotation, one-sixteenth scale, zero centre, colour 15)
// ----------------------------------------------------------------------------
// hermite_curve_point_transform
// Evaluates a cubic Hermite segment at t, rotates, scales and offsets the
// point and emits a saturated pixel coordinate with the drawing colour.
// ----------------------------------------------------------------------------
`default_nettype none

module hermite_curve_point_transform #(
  parameter int T_FRAC_BITS    = hcpt_pkg::T_FRAC_BITS_DEF,
  parameter int TRIG_FRAC_BITS = hcpt_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // start_x, start_y, end_x, end_y, tan_start_x, tan_start_y,
  // tan_end_x, tan_end_y, t_param, zero pad
  input  wire logic [hcpt_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [hcpt_pkg::OUT_TDATA_W-1:0]         m_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [hcpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hcpt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int HW = T_FRAC_BITS + 4;

  hcpt_pkg::cfg_t cfg;
  hcpt_pkg::seg_t seg_in, seg_b;

  logic                 b_valid, b_ready;
  logic signed [HW-1:0] h00, h01, h10, h11;
  logic                 x_valid, x_ready;
  logic signed [hcpt_pkg::BLEND_W-1:0] bx, by;
  logic [hcpt_pkg::COORD_W-1:0] pixel_x, pixel_y;
  logic [hcpt_pkg::COLOR_W-1:0] pixel_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= hcpt_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcpt_pkg::REG_COS_ANGLE:  cfg.cos_angle  <= cfg_data;
        hcpt_pkg::REG_SIN_ANGLE:  cfg.sin_angle  <= cfg_data;
        hcpt_pkg::REG_SCALE_X:    cfg.scale_x    <= cfg_data;
        hcpt_pkg::REG_SCALE_Y:    cfg.scale_y    <= cfg_data;
        hcpt_pkg::REG_CENTER_X:   cfg.center_x   <= cfg_data[hcpt_pkg::CENTER_W-1:0];
        hcpt_pkg::REG_CENTER_Y:   cfg.center_y   <= cfg_data[hcpt_pkg::CENTER_W-1:0];
        hcpt_pkg::REG_DRAW_COLOR: cfg.draw_color <= cfg_data[hcpt_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign seg_in = s_tdata[8*hcpt_pkg::COORD_W-1:0];

  hcpt_basis #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_basis (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_t      (s_tdata[8*hcpt_pkg::COORD_W +: hcpt_pkg::T_IN_W]),
    .in_seg    (seg_in),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .h00       (h00),
    .h01       (h01),
    .h10       (h10),
    .h11       (h11),
    .out_seg   (seg_b)
  );

  hcpt_blend #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .h00       (h00),
    .h01       (h01),
    .h10       (h10),
    .h11       (h11),
    .in_seg    (seg_b),
    .out_valid (x_valid),
    .out_ready (x_ready),
    .bx        (bx),
    .by        (by)
  );

  hcpt_xform #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_xform (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (x_valid),
    .in_ready    (x_ready),
    .bx          (bx),
    .by          (by),
    .cfg         (cfg),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color)
  );

  assign m_tdata = {4'b0000, pixel_color, pixel_y, pixel_x};

`ifndef SYNTHESIS
  // input held back only when every stage is full and the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while pipeline has room");

  // with the output never stalled, an accepted word reaches m_tvalid
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
    ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("word lost in pipeline");
`endif

endmodule

`default_nettype wire

/* tb/sv/hcpt_pixel_checker.sv */
// ----------------------------------------------------------------------------
// hcpt_pixel_checker
// Watches the segment, pixel and register ports of the Hermite curve point
// transform. It keeps its own copy of the registers and works out the pixel
// for every accepted segment word. Each pixel word is then compared field by
// field with the oldest pixel still owed.
// ----------------------------------------------------------------------------
module hcpt_pixel_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  // start_x, start_y, end_x, end_y, tan_start_x, tan_start_y,
  // tan_end_x, tan_end_y, t_param, zero pad
  input  logic [hcpt_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  input  logic [hcpt_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_we,
  input  logic [hcpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hcpt_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   mismatches,
  output int                                   pending,
  output int                                   pixels_checked,
  output int                                   clipped
);
  timeunit 1ns;
  timeprecision 1ps;

  import hcpt_pkg::*;

  localparam int     T_FRAC    = T_FRAC_BITS_DEF;
  localparam int     TRIG_FRAC = TRIG_FRAC_BITS_DEF;
  localparam longint T_ONE     = longint'(1) << T_FRAC;
  localparam longint PIXEL_ONE = longint'(1) << (16 + TRIG_FRAC);
  localparam int     PIXEL_W   = 2 * COORD_W + COLOR_W;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } pixel_t;

  cfg_t   settings;
  pixel_t expected_pixels[$];
  pixel_t want;
  pixel_t got;
  int     fail_count;
  int     compared;
  int     at_limit;

  // centre offset plus scaled rotated coordinate, truncated, then clamped
  function automatic logic [COORD_W-1:0] place_axis(longint rot, longint scale,
                                                    longint centre);
    longint v;
    v = (centre * PIXEL_ONE + rot * scale) / PIXEL_ONE;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[COORD_W-1:0];
  endfunction

  function automatic pixel_t hermite_pixel(seg_t seg, logic [T_IN_W-1:0] t_raw,
                                           cfg_t c);
    pixel_t px;
    longint t, t2, t3, h00, h01, h10, h11;
    longint p0x, p0y, p1x, p1y, r0x, r0y, r1x, r1y;
    longint bx, by, cs, sn, rx, ry;
    p0x = $signed(seg.start_x);
    p0y = $signed(seg.start_y);
    p1x = $signed(seg.end_x);
    p1y = $signed(seg.end_y);
    r0x = $signed(seg.tan_start_x);
    r0y = $signed(seg.tan_start_y);
    r1x = $signed(seg.tan_end_x);
    r1y = $signed(seg.tan_end_y);
    t = t_raw;
    if (t > T_ONE) t = T_ONE;
    t2 = (t * t) >> T_FRAC;
    t3 = (t2 * t) >> T_FRAC;
    h00 = 2 * t3 - 3 * t2 + T_ONE;
    h01 = 3 * t2 - 2 * t3;
    h10 = t3 - 2 * t2 + t;
    h11 = t3 - t2;
    bx = (h00 * p0x + h01 * p1x + h10 * r0x + h11 * r1x) / T_ONE;
    by = (h00 * p0y + h01 * p1y + h10 * r0y + h11 * r1y) / T_ONE;
    cs = $signed(c.cos_angle);
    sn = $signed(c.sin_angle);
    rx = bx * cs - by * sn;
    ry = bx * sn + by * cs;
    px.x = place_axis(rx, c.scale_x, $signed(c.center_x));
    px.y = place_axis(ry, c.scale_y, $signed(c.center_y));
    px.color = c.draw_color;
    return px;
  endfunction

  initial begin
    fail_count = 0;
    compared = 0;
    at_limit = 0;
    mismatches = 0;
    pending = 0;
    pixels_checked = 0;
    clipped = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      settings = CFG_RESET;
      expected_pixels.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = pixel_t'(m_tdata[PIXEL_W-1:0]);
        compared++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: pixel word %h arrived with nothing owed", $time, m_tdata);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x) begin
            $display("%0t: pixel_x expected %0d, got %0d", $time,
                     $signed(want.x), $signed(got.x));
            fail_count++;
          end
          if (got.y !== want.y) begin
            $display("%0t: pixel_y expected %0d, got %0d", $time,
                     $signed(want.y), $signed(got.y));
            fail_count++;
          end
          if (got.color !== want.color) begin
            $display("%0t: pixel_color expected %0d, got %0d", $time,
                     want.color, got.color);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_COS_ANGLE:  settings.cos_angle  = cfg_data[TRIG_W-1:0];
          REG_SIN_ANGLE:  settings.sin_angle  = cfg_data[TRIG_W-1:0];
          REG_SCALE_X:    settings.scale_x    = cfg_data[SCALE_W-1:0];
          REG_SCALE_Y:    settings.scale_y    = cfg_data[SCALE_W-1:0];
          REG_CENTER_X:   settings.center_x   = cfg_data[CENTER_W-1:0];
          REG_CENTER_Y:   settings.center_y   = cfg_data[CENTER_W-1:0];
          REG_DRAW_COLOR: settings.draw_color = cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = hermite_pixel(seg_t'(s_tdata[8*COORD_W-1:0]),
                             s_tdata[8*COORD_W +: T_IN_W], settings);
        if (want.x == 16'h7FFF || want.x == 16'h8000 ||
            want.y == 16'h7FFF || want.y == 16'h8000) begin
          at_limit++;
        end
        expected_pixels.push_back(want);
      end
    end
    mismatches <= fail_count;
    pending <= expected_pixels.size();
    pixels_checked <= compared;
    clipped <= at_limit;
  end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives segment words into the Hermite curve point transform under a run of
// register settings: the reset values, out-of-range trig with full scale,
// tiny scale, then random settings. Both stream sides stall in random bursts
// except at the end. A separate checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hcpt_pkg::*;

  localparam int                   WATCHDOG_LIMIT = 2000;
  localparam int                   RANDOM_PHASES  = 8;
  localparam int                   PHASE_WORDS    = 54;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;
  localparam logic [COORD_W-1:0]   CMAX           = 16'h7FFF;
  localparam logic [COORD_W-1:0]   CMIN           = 16'h8000;
  localparam logic [T_IN_W-1:0]    T_ONE          = 17'h10000;
  localparam logic [T_IN_W-1:0]    T_MAX          = 17'h1FFFF;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches;
  int pending;
  int pixels_checked;
  int clipped;
  int n_segments = 0;
  int n_clamped = 0;
  int n_settings = 1;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  always #5 clk = ~clk;

  hermite_curve_point_transform dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hcpt_pixel_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .pixels_checked (pixels_checked),
    .clipped        (clipped)
  );

  function automatic seg_t make_seg(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                    logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                                    logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                                    logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by);
    seg_t seg;
    seg.start_x = sx;
    seg.start_y = sy;
    seg.end_x = ex;
    seg.end_y = ey;
    seg.tan_start_x = ax;
    seg.tan_start_y = ay;
    seg.tan_end_x = bx;
    seg.tan_end_y = by;
    return seg;
  endfunction

  // small coordinates now and then so that large scales do not always clip
  function automatic logic [COORD_W-1:0] random_coord();
    if ($urandom_range(0, 3) == 0) return 16'(int'($urandom_range(0, 1023)) - 512);
    return 16'($urandom);
  endfunction

  function automatic logic [TRIG_W-1:0] random_trig();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'hC000;
      2: return 16'h4000;
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] random_scale();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'h0000;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(1024, 8192));
    endcase
  endfunction

  function automatic cfg_t make_settings(logic [TRIG_W-1:0] cs, logic [TRIG_W-1:0] sn,
                                         logic [SCALE_W-1:0] kx, logic [SCALE_W-1:0] ky,
                                         logic [CENTER_W-1:0] cx, logic [CENTER_W-1:0] cy,
                                         logic [COLOR_W-1:0] colour);
    cfg_t c;
    c.cos_angle = cs;
    c.sin_angle = sn;
    c.scale_x = kx;
    c.scale_y = ky;
    c.center_x = cx;
    c.center_y = cy;
    c.draw_color = colour;
    return c;
  endfunction

  task automatic send_segment(input seg_t seg, input logic [T_IN_W-1:0] t);
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_TDATA_W - T_IN_W - 8 * COORD_W){1'b0}}, t, seg};
    do @(posedge clk); while (!s_tready);
    n_segments++;
    if (t > T_ONE) n_clamped++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic random_segments(input int n);
    seg_t             seg;
    logic [T_IN_W-1:0] t;
    repeat (n) begin
      seg = make_seg(random_coord(), random_coord(), random_coord(), random_coord(),
                     random_coord(), random_coord(), random_coord(), random_coord());
      case ($urandom_range(0, 9))
        0: t = '0;
        1: t = T_ONE;
        2: t = 17'($urandom_range(T_ONE + 1, T_MAX));
        default: t = 17'($urandom_range(0, T_ONE));
      endcase
      send_segment(seg, t);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // upper data bits of the narrow registers are random and must be ignored
  task automatic apply_settings(input cfg_t c);
    write_reg(REG_COS_ANGLE, c.cos_angle);
    write_reg(REG_SIN_ANGLE, c.sin_angle);
    write_reg(REG_SCALE_X, c.scale_x);
    write_reg(REG_SCALE_Y, c.scale_y);
    write_reg(REG_CENTER_X, {4'($urandom), c.center_x});
    write_reg(REG_CENTER_Y, {4'($urandom), c.center_y});
    write_reg(REG_DRAW_COLOR, {12'($urandom), c.draw_color});
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // sink side: ready in random bursts, always high once idling is off
  initial begin
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (idle_on && $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("hermite_curve_point_transform verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: end points, clamped t and extreme fields
    send_segment(make_seg('0, '0, '0, '0, '0, '0, '0, '0), '0);
    send_segment(make_seg(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), T_ONE);
    send_segment(make_seg(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX), '0);
    send_segment(make_seg(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX), T_ONE);
    send_segment(make_seg(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX), T_ONE + 1);
    send_segment(make_seg(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), T_MAX);
    send_segment(make_seg(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                          16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555), 17'h0AAAA);
    send_segment(make_seg(CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN), 17'h08000);
    send_segment(make_seg(random_coord(), random_coord(), random_coord(), random_coord(),
                          random_coord(), random_coord(), random_coord(), random_coord()),
                 17'h00001);
    send_segment(make_seg(16'h0010, 16'hFFF0, 16'h0020, 16'hFFE0,
                          16'h0100, 16'hFF00, 16'h0100, 16'hFF00), 17'h15555);
    drain();

    // trig beyond unity, full scale and extreme centres drive the clamp
    apply_settings(make_settings(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF,
                                 12'h7FF, 12'h800, 4'h0));
    send_segment(make_seg(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), '0);
    send_segment(make_seg(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), '0);
    send_segment(make_seg(CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMAX), 17'h08000);
    send_segment(make_seg(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                          16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555), T_MAX);
    send_segment(make_seg(16'h0010, 16'h0010, 16'hFFF0, 16'h0010,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000), 17'h04000);
    random_segments(1);
    drain();

    apply_settings(make_settings(16'hC000, 16'h4000, 16'h0000, 16'h0001,
                                 12'h800, 12'h7FF, 4'hA));
    random_segments(5);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_settings(make_settings(random_trig(), random_trig(), random_scale(),
                                   random_scale(), 12'($urandom), 12'($urandom),
                                   4'($urandom)));
      if (p == RANDOM_PHASES - 1) idle_on = 1'b0;
      random_segments(PHASE_WORDS);
      drain();
    end

    repeat (20) @(posedge clk);
    $display("%0d segments over %0d register settings, %0d with t clamped to one",
             n_segments, n_settings, n_clamped);
    $display("%0d pixel words compared, %0d at the coordinate limits",
             pixels_checked, clipped);
    if (mismatches == 0) begin
      $display("hermite_curve_point_transform verification clean");
    end else begin
      $display("hermite_curve_point_transform verification failed");
    end
    $finish;
  end

endmodule
